// ----- src/avclp_pkg.sv -----
// ----------------------------------------------------------------------------
// avclp_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package avclp_pkg;

    // Field widths fixed by the byte stream format.
    localparam int BYTE_W  = 8;
    localparam int LSIZE_W = 3;
    localparam int CNT_W   = 3;
    localparam int ACCUM_W = 32;

    // Register reset value and start code tail byte.
    localparam logic [LSIZE_W-1:0] LSIZE_RESET     = 3'd4;
    localparam logic [BYTE_W-1:0]  START_CODE_TAIL = 8'h01;

    // Error codes carried on the result that closes a buffer.
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_PREFIX  = 2'd1,
        ERR_OVERRUN = 2'd2
    } err_t;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    // One queued command: all results caused by one input item.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   data;
        logic                long_code;
        logic                done;
        err_t                err;
    } cmd_t;

endpackage

// ----- src/avclp_ifs.sv -----
// ----------------------------------------------------------------------------
// avclp channel interfaces
// Valid/ready channels for input bytes, output results and configuration.
// ----------------------------------------------------------------------------
interface avclp_in_if;
    logic                        valid;
    logic                        ready;
    logic [avclp_pkg::BYTE_W-1:0] in_byte;
    logic                        buffer_end;

    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface avclp_out_if;
    logic                        valid;
    logic                        ready;
    logic [avclp_pkg::BYTE_W-1:0] out_byte;
    logic                        byte_valid;
    logic                        run_last;
    logic                        buffer_done;
    logic [1:0]                  err_code;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output buffer_done, output err_code, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input buffer_done, input err_code, output ready);
endinterface

interface avclp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [avclp_pkg::LSIZE_W-1:0] length_size;

    modport source (output valid, output length_size, input ready);
    modport sink   (input valid, input length_size, output ready);
endinterface

// ----- src/avclp_front.sv -----
// ----------------------------------------------------------------------------
// avclp_front
// Accepts input bytes, tracks prefix/payload state and queues one command
// per byte that produces results.
// ----------------------------------------------------------------------------
module avclp_front #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    avclp_in_if.sink          din,
    avclp_cfg_if.sink         cfg,
    input  logic              push_ready,
    output logic              push_valid,
    output avclp_pkg::cmd_t   push_cmd
);

    logic [avclp_pkg::LSIZE_W-1:0] length_size_reg;
    logic                          in_payload_reg, in_payload_next;
    logic                          discarding_reg, discarding_next;
    logic [avclp_pkg::CNT_W-1:0]   prefix_count_reg, prefix_count_next;
    logic [avclp_pkg::ACCUM_W-1:0] length_accum_reg, length_accum_next;
    logic [LENGTH_WIDTH-1:0]       bytes_remaining_reg, bytes_remaining_next;

    logic                          accept;
    logic [avclp_pkg::LSIZE_W-1:0] eff_size;
    logic [avclp_pkg::ACCUM_W-1:0] new_accum;
    logic                          too_wide;
    logic [avclp_pkg::CNT_W-1:0]   count_inc;
    logic [LENGTH_WIDTH-1:0]       rem_dec;
    logic [LENGTH_WIDTH-1:0]       new_len;

    assign cfg.ready = 1'b1;
    assign din.ready = push_ready;
    assign accept    = din.valid && din.ready;

    // Effective prefix size: zero acts as one, above four acts as four.
    always_comb
    begin
        if (length_size_reg == '0)
            eff_size = avclp_pkg::LSIZE_W'(1);
        else if (length_size_reg > avclp_pkg::LSIZE_W'(4))
            eff_size = avclp_pkg::LSIZE_W'(4);
        else
            eff_size = length_size_reg;
    end

    // Prefix accumulation and payload countdown arithmetic.
    assign new_accum = {length_accum_reg[avclp_pkg::ACCUM_W-avclp_pkg::BYTE_W-1:0], din.in_byte};
    assign too_wide  = (new_accum >> LENGTH_WIDTH) != '0;
    assign new_len   = new_accum[LENGTH_WIDTH-1:0];
    assign count_inc = prefix_count_reg + avclp_pkg::CNT_W'(1);
    assign rem_dec   = bytes_remaining_reg - LENGTH_WIDTH'(1);

    // Classify the accepted byte and build its command.
    always_comb
    begin
        in_payload_next      = in_payload_reg;
        discarding_next      = discarding_reg;
        prefix_count_next    = prefix_count_reg;
        length_accum_next    = length_accum_reg;
        bytes_remaining_next = bytes_remaining_reg;
        push_valid           = 1'b0;
        push_cmd.kind        = avclp_pkg::CMD_STATUS;
        push_cmd.data        = '0;
        push_cmd.long_code   = 1'b0;
        push_cmd.done        = din.buffer_end;
        push_cmd.err         = avclp_pkg::ERR_NONE;

        if (accept)
        begin
            if (discarding_reg)
            begin
                if (din.buffer_end)
                begin
                    push_valid   = 1'b1;
                    push_cmd.err = avclp_pkg::ERR_OVERRUN;
                end
            end
            else if (in_payload_reg)
            begin
                bytes_remaining_next = rem_dec;
                in_payload_next      = rem_dec != '0;
                push_valid           = 1'b1;
                push_cmd.kind        = avclp_pkg::CMD_BYTE;
                push_cmd.data        = din.in_byte;
                if (din.buffer_end && rem_dec != '0)
                    push_cmd.err = avclp_pkg::ERR_OVERRUN;
            end
            else
            begin
                length_accum_next = new_accum;
                prefix_count_next = count_inc;
                if (count_inc >= eff_size)
                begin
                    prefix_count_next = '0;
                    length_accum_next = '0;
                    if (too_wide)
                    begin
                        discarding_next = 1'b1;
                        if (din.buffer_end)
                        begin
                            push_valid   = 1'b1;
                            push_cmd.err = avclp_pkg::ERR_OVERRUN;
                        end
                    end
                    else
                    begin
                        bytes_remaining_next = new_len;
                        in_payload_next      = new_len != '0;
                        push_valid           = 1'b1;
                        push_cmd.kind        = avclp_pkg::CMD_START;
                        push_cmd.long_code   = eff_size != avclp_pkg::LSIZE_W'(3);
                        if (din.buffer_end && new_len != '0)
                            push_cmd.err = avclp_pkg::ERR_OVERRUN;
                    end
                end
                else if (din.buffer_end)
                begin
                    push_valid   = 1'b1;
                    push_cmd.err = avclp_pkg::ERR_PREFIX;
                end
            end

            // Every buffer end returns the stream state to its reset value.
            if (din.buffer_end)
            begin
                in_payload_next      = 1'b0;
                discarding_next      = 1'b0;
                prefix_count_next    = '0;
                length_accum_next    = '0;
                bytes_remaining_next = '0;
            end
        end
    end

    // Stream state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_size_reg     <= avclp_pkg::LSIZE_RESET;
            in_payload_reg      <= 1'b0;
            discarding_reg      <= 1'b0;
            prefix_count_reg    <= '0;
            length_accum_reg    <= '0;
            bytes_remaining_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                length_size_reg <= cfg.length_size;
            in_payload_reg      <= in_payload_next;
            discarding_reg      <= discarding_next;
            prefix_count_reg    <= prefix_count_next;
            length_accum_reg    <= length_accum_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

endmodule

// ----- src/avclp_queue.sv -----
// ----------------------------------------------------------------------------
// avclp_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module avclp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  avclp_pkg::cmd_t  push_cmd,
    output logic             push_ready,
    output logic             head_valid,
    output avclp_pkg::cmd_t  head_cmd,
    input  logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    avclp_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- src/avclp_back.sv -----
// ----------------------------------------------------------------------------
// avclp_back
// Expands queued commands into result items through an output register.
// ----------------------------------------------------------------------------
module avclp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  avclp_pkg::cmd_t  head_cmd,
    output logic             pop,
    avclp_out_if.source      dout
);

    logic                         valid_reg, valid_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [avclp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                         bv_reg, bv_next;
    logic                         last_reg, last_next;
    logic                         done_reg, done_next;
    avclp_pkg::err_t              err_reg, err_next;

    logic                         load;
    logic [1:0]                   zeros;

    assign load  = !valid_reg || dout.ready;
    assign zeros = head_cmd.long_code ? 2'd3 : 2'd2;

    // Pick the next result from the command at the queue head.
    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        err_next   = err_reg;

        if (load)
        begin
            valid_next = head_valid;
            byte_next  = '0;
            bv_next    = 1'b1;
            last_next  = 1'b1;
            done_next  = head_cmd.done;
            err_next   = head_cmd.err;
            if (head_valid)
            begin
                unique case (head_cmd.kind)
                    avclp_pkg::CMD_BYTE:
                    begin
                        byte_next = head_cmd.data;
                        pop       = 1'b1;
                    end
                    avclp_pkg::CMD_START:
                    begin
                        if (phase_reg < zeros)
                        begin
                            // Leading zero bytes of the start code.
                            last_next  = 1'b0;
                            done_next  = 1'b0;
                            err_next   = avclp_pkg::ERR_NONE;
                            phase_next = phase_reg + 2'd1;
                        end
                        else
                        begin
                            byte_next  = avclp_pkg::START_CODE_TAIL;
                            phase_next = '0;
                            pop        = 1'b1;
                        end
                    end
                    avclp_pkg::CMD_STATUS:
                    begin
                        bv_next = 1'b0;
                        pop     = 1'b1;
                    end
                    default:
                    begin
                        bv_next = 1'b0;
                        pop     = 1'b1;
                    end
                endcase
            end
        end
    end

    // Output register and start code phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= '0;
            byte_reg  <= '0;
            bv_reg    <= 1'b0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
            err_reg   <= avclp_pkg::ERR_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            byte_reg  <= byte_next;
            bv_reg    <= bv_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

    assign dout.valid       = valid_reg;
    assign dout.out_byte    = byte_reg;
    assign dout.byte_valid  = bv_reg;
    assign dout.run_last    = last_reg;
    assign dout.buffer_done = done_reg;
    assign dout.err_code    = err_reg;

endmodule

// ----- src/avc_length_prefix_to_start_code_core.sv -----
// ----------------------------------------------------------------------------
// avc_length_prefix_to_start_code_core
// Converts length-prefixed H.264 NAL units into start-code delimited units.
// ----------------------------------------------------------------------------
// Path: an accepted item is written to the command queue, then to the output
// register, from which its first result is shown.
// Throughput: one input byte per cycle while the output keeps pace; a start code
// occupies the output for 3 or 4 results, and the QUEUE_DEPTH-entry queue absorbs them.
// Reset: clears the stream state, empties the queue and sets length_size to 4.
module avc_length_prefix_to_start_code_core #(
    parameter int LENGTH_WIDTH = 32,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    avclp_in_if.sink     din,
    avclp_out_if.source  dout,
    avclp_cfg_if.sink    cfg
);

    logic             push_valid;
    logic             push_ready;
    avclp_pkg::cmd_t  push_cmd;
    logic             head_valid;
    avclp_pkg::cmd_t  head_cmd;
    logic             pop;

    // Front end: classification and stream state.
    avclp_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .cfg        (cfg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // Command queue between the two halves.
    avclp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // Back end: result generation.
    avclp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .dout       (dout)
    );

endmodule

// ----- src/avclp_checker.sv -----
// ----------------------------------------------------------------------------
// avclp_checker
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
module avclp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       buffer_done,
    input logic [1:0] err_code
);

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
                                    && $stable(buffer_done) && $stable(err_code))
        else $error("stalled result changed");

    // Errors appear only on the result that closes a buffer.
    a_err_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err_code != avclp_pkg::ERR_NONE |-> buffer_done)
        else $error("error code without buffer end");

    // A status-only result is a lone, buffer-closing result with a zero byte.
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> run_last && buffer_done && out_byte == 8'h00)
        else $error("malformed status-only result");

    // The buffer-closing result is always the last one of its item.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_done |-> run_last)
        else $error("buffer end before last result of item");

endmodule

bind avc_length_prefix_to_start_code_core avclp_checker u_avclp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .out_byte    (dout.out_byte),
    .byte_valid  (dout.byte_valid),
    .run_last    (dout.run_last),
    .buffer_done (dout.buffer_done),
    .err_code    (dout.err_code)
);
